// File: rtl/dsbfir_pkg.sv
`default_nettype none

package dsbfir_pkg;

  // Delay line depth; the filter has one tap more than the delay line.
  localparam int DELAY_DEPTH = 1024;
  localparam int TAP_COUNT   = DELAY_DEPTH + 1;
  localparam int TAP_AW      = $clog2(TAP_COUNT);
  localparam int DLY_AW      = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;

  localparam int SAMPLE_W  = 16;
  localparam int ACC_W     = 32;
  localparam int FRAC_BITS = 15;
  localparam int INDEX_W   = 11;

  // Input item kinds
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_TAP    = 1'b1;

  // One issue slot of the shared multiplier
  typedef struct packed {
    logic mix;    // multiply the two input samples this cycle
    logic term;   // a filter term is being read from memory this cycle
    logic first;  // the term is tap 0, weighting the fresh DSB value
    logic zero;   // the delay entry was never filled, its sample reads as zero
  } mac_issue_t;

  // Bits 30..15 of a 32-bit word
  function automatic logic [SAMPLE_W-1:0] q15_take(input logic [ACC_W-1:0] w);
    q15_take = w[FRAC_BITS +: SAMPLE_W];
  endfunction

endpackage

`default_nettype wire

// File: rtl/dsbfir_ram.sv
`default_nettype none

module dsbfir_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/dsbfir_mac.sv
`default_nettype none

module dsbfir_mac (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire dsbfir_pkg::mac_issue_t              iss,
  input  wire logic signed [dsbfir_pkg::SAMPLE_W-1:0] mix_a,
  input  wire logic signed [dsbfir_pkg::SAMPLE_W-1:0] mix_b,
  input  wire logic signed [dsbfir_pkg::SAMPLE_W-1:0] smp_data,
  input  wire logic signed [dsbfir_pkg::SAMPLE_W-1:0] tap_data,
  output logic             [dsbfir_pkg::ACC_W-1:0]    acc,
  output logic             [dsbfir_pkg::SAMPLE_W-1:0] dsb,
  output logic                                         busy
);

  // stage B: memory data present, multiply; stage C: accumulate
  logic                                        b_valid_r, b_valid_nxt;
  logic                                        b_first_r, b_first_nxt;
  logic                                        b_zero_r, b_zero_nxt;
  logic                                        c_valid_r, c_valid_nxt;
  logic                                        c_first_r, c_first_nxt;
  logic signed [dsbfir_pkg::ACC_W-1:0]         prod_r, prod_nxt;
  logic        [dsbfir_pkg::ACC_W-1:0]         acc_r, acc_nxt;
  logic        [dsbfir_pkg::SAMPLE_W-1:0]      dsb_r, dsb_nxt;
  logic signed [dsbfir_pkg::SAMPLE_W-1:0]      op_a, op_b;
  logic signed [dsbfir_pkg::ACC_W-1:0]         mul;

  always_comb begin
    if (iss.mix) begin
      op_a = mix_a;
      op_b = mix_b;
    end else begin
      if (b_first_r) begin
        op_a = signed'(dsbfir_pkg::q15_take(prod_r));
      end else if (b_zero_r) begin
        op_a = '0;
      end else begin
        op_a = smp_data;
      end
      op_b = tap_data;
    end
  end

  assign mul = op_a * op_b;

  always_comb begin
    b_valid_nxt = iss.term;
    b_first_nxt = iss.first;
    b_zero_nxt  = iss.zero;
    c_valid_nxt = b_valid_r;
    c_first_nxt = b_first_r;
    prod_nxt    = prod_r;
    acc_nxt     = acc_r;
    dsb_nxt     = dsb_r;
    if (iss.mix || b_valid_r) begin
      prod_nxt = mul;
    end
    // capture the mixer output as it feeds tap 0
    if (b_valid_r && b_first_r) begin
      dsb_nxt = dsbfir_pkg::q15_take(prod_r);
    end
    if (c_valid_r) begin
      acc_nxt = c_first_r ? prod_r : acc_r + prod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
      c_valid_r <= c_valid_nxt;
    end
    b_first_r <= b_first_nxt;
    b_zero_r  <= b_zero_nxt;
    c_first_r <= c_first_nxt;
    prod_r    <= prod_nxt;
    acc_r     <= acc_nxt;
    dsb_r     <= dsb_nxt;
  end

  assign acc  = acc_r;
  assign dsb  = dsb_r;
  assign busy = b_valid_r || c_valid_r;

`ifndef SYNTHESIS
  a_mix_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    !(iss.mix && b_valid_r))
    else $error("mixer multiply collides with a filter term");

  a_term_reaches_acc: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |=> c_valid_r)
    else $error("filter term lost between multiply and accumulate");

  a_first_inits_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (c_valid_r && c_first_r) |=> (acc_r == $past(prod_r)))
    else $error("accumulator not restarted by tap 0");
`endif

endmodule

`default_nettype wire

// File: rtl/dsb_mixer_fir_filter_unit.sv
`default_nettype none

// DSB mixer and 1025-tap Q15 FIR. A tap write is taken without leaving the idle
// state. A sample pair passes through the mixer product, then one tap per cycle
// through the single shared 16x16 multiplier and 32-bit accumulator, then a
// drain of the multiply/accumulate pipeline, before the next item can be taken.
// The result sits in an output register, so the next item can be taken while
// it waits. Taps live in a single-port-read RAM; the delay line is a circular
// RAM whose unfilled entries read as zero through a fill count, so no
// clearing pass runs after reset. Write all taps before the first sample.
module dsb_mixer_fir_filter_unit (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic                                   in_action,
  input  wire logic signed [dsbfir_pkg::SAMPLE_W-1:0] in_modulating_sample,
  input  wire logic signed [dsbfir_pkg::SAMPLE_W-1:0] in_carrier_sample,
  input  wire logic        [dsbfir_pkg::INDEX_W-1:0]  in_tap_index,
  input  wire logic signed [dsbfir_pkg::SAMPLE_W-1:0] in_tap_value,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed      [dsbfir_pkg::SAMPLE_W-1:0] out_dsb_value,
  output logic signed      [dsbfir_pkg::SAMPLE_W-1:0] out_filtered_value
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX,
    ST_MAC,
    ST_DRAIN
  } state_t;

  localparam logic [dsbfir_pkg::DLY_AW-1:0] DLY_LAST =
    dsbfir_pkg::DLY_AW'(dsbfir_pkg::DELAY_DEPTH - 1);
  localparam logic [dsbfir_pkg::TAP_AW-1:0] TAP_LAST =
    dsbfir_pkg::TAP_AW'(dsbfir_pkg::DELAY_DEPTH);

  state_t                                   state_r, state_nxt;
  logic signed [dsbfir_pkg::SAMPLE_W-1:0]   mod_r, mod_nxt;
  logic signed [dsbfir_pkg::SAMPLE_W-1:0]   car_r, car_nxt;
  logic        [dsbfir_pkg::TAP_AW-1:0]     iss_k_r, iss_k_nxt;
  logic        [dsbfir_pkg::TAP_AW-1:0]     fill_r, fill_nxt;
  logic        [dsbfir_pkg::DLY_AW-1:0]     dly_addr_r, dly_addr_nxt;
  logic        [dsbfir_pkg::DLY_AW-1:0]     head_r, head_nxt;
  logic                                     out_valid_r, out_valid_nxt;
  logic        [dsbfir_pkg::SAMPLE_W-1:0]   out_dsb_r, out_dsb_nxt;
  logic        [dsbfir_pkg::SAMPLE_W-1:0]   out_filt_r, out_filt_nxt;

  logic                                     in_xfer;
  logic                                     tap_we;
  logic                                     drain_done;
  dsbfir_pkg::mac_issue_t                   iss;
  logic        [dsbfir_pkg::SAMPLE_W-1:0]   tap_rdata;
  logic        [dsbfir_pkg::SAMPLE_W-1:0]   dly_rdata;
  logic        [dsbfir_pkg::ACC_W-1:0]      mac_acc;
  logic        [dsbfir_pkg::SAMPLE_W-1:0]   mac_dsb;
  logic                                     mac_busy;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign tap_we   = in_xfer && (in_action == dsbfir_pkg::ACT_TAP) &&
                    (32'(in_tap_index) <= dsbfir_pkg::DELAY_DEPTH);
  assign drain_done = (state_r == ST_DRAIN) && !mac_busy &&
                      (!out_valid_r || out_ready);

  dsbfir_ram #(
    .DEPTH (dsbfir_pkg::TAP_COUNT),
    .AW    (dsbfir_pkg::TAP_AW),
    .DW    (dsbfir_pkg::SAMPLE_W)
  ) u_tap_ram (
    .clk   (clk),
    .we    (tap_we),
    .waddr (dsbfir_pkg::TAP_AW'(in_tap_index)),
    .wdata (in_tap_value),
    .raddr (iss_k_r),
    .rdata (tap_rdata)
  );

  dsbfir_ram #(
    .DEPTH (dsbfir_pkg::DELAY_DEPTH),
    .AW    (dsbfir_pkg::DLY_AW),
    .DW    (dsbfir_pkg::SAMPLE_W)
  ) u_dly_ram (
    .clk   (clk),
    .we    (drain_done),
    .waddr (head_r),
    .wdata (mac_dsb),
    .raddr (dly_addr_r),
    .rdata (dly_rdata)
  );

  dsbfir_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .iss      (iss),
    .mix_a    (mod_r),
    .mix_b    (car_r),
    .smp_data (dly_rdata),
    .tap_data (tap_rdata),
    .acc      (mac_acc),
    .dsb      (mac_dsb),
    .busy     (mac_busy)
  );

  always_comb begin
    state_nxt     = state_r;
    mod_nxt       = mod_r;
    car_nxt       = car_r;
    iss_k_nxt     = iss_k_r;
    fill_nxt      = fill_r;
    dly_addr_nxt  = dly_addr_r;
    head_nxt      = head_r;
    out_valid_nxt = out_valid_r;
    out_dsb_nxt   = out_dsb_r;
    out_filt_nxt  = out_filt_r;
    iss           = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_action == dsbfir_pkg::ACT_SAMPLE)) begin
          mod_nxt   = in_modulating_sample;
          car_nxt   = in_carrier_sample;
          iss_k_nxt = '0;
          state_nxt = ST_MIX;
        end
      end
      ST_MIX: begin
        // mixer product and tap 0 read share this cycle
        iss.mix      = 1'b1;
        iss.term     = 1'b1;
        iss.first    = 1'b1;
        iss_k_nxt    = iss_k_r + 1'b1;
        dly_addr_nxt = (head_r == '0) ? DLY_LAST : head_r - 1'b1;
        state_nxt    = ST_MAC;
      end
      ST_MAC: begin
        iss.term     = 1'b1;
        iss.zero     = (iss_k_r > fill_r);
        dly_addr_nxt = (dly_addr_r == '0) ? DLY_LAST : dly_addr_r - 1'b1;
        if (iss_k_r == TAP_LAST) begin
          state_nxt = ST_DRAIN;
        end else begin
          iss_k_nxt = iss_k_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (drain_done) begin
          out_valid_nxt = 1'b1;
          out_dsb_nxt   = mac_dsb;
          out_filt_nxt  = dsbfir_pkg::q15_take(mac_acc);
          head_nxt      = (head_r == DLY_LAST) ? '0 : head_r + 1'b1;
          if (fill_r != TAP_LAST) begin
            fill_nxt = fill_r + 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mod_r      <= mod_nxt;
    car_r      <= car_nxt;
    iss_k_r    <= iss_k_nxt;
    dly_addr_r <= dly_addr_nxt;
    out_dsb_r  <= out_dsb_nxt;
    out_filt_r <= out_filt_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_dsb_value      = out_dsb_r;
  assign out_filtered_value = out_filt_r;

`ifndef SYNTHESIS
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mac_busy)
    else $error("multiply pipeline busy while idle");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= TAP_LAST)
    else $error("delay fill count past depth");

  a_one_result_per_sample: assert property (@(posedge clk) disable iff (!rst_n)
    drain_done |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("finished sample did not reach the output register");

  a_mix_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MIX) |-> ($past(state_r) == ST_IDLE))
    else $error("mixer step entered without a sample transfer");
`endif

endmodule

`default_nettype wire

// File: tb/tb_top.sv
module tb_top;
  import dsbfir_pkg::*;

  localparam int CLK_HALF   = 10;
  localparam int MAX_CYCLES = 3_000_000;
  localparam int TAIL_WAIT  = DELAY_DEPTH + 80;
  localparam int LONG_HOLD  = 4 * (DELAY_DEPTH + 5);
  localparam int RAND_ITEMS = 580;

  typedef struct {
    logic signed [SAMPLE_W-1:0] dsb;
    logic signed [SAMPLE_W-1:0] filtered;
  } mixer_out_t;

  class dsb_fir_scoreboard;
    logic signed [SAMPLE_W-1:0] taps [TAP_COUNT];
    logic signed [SAMPLE_W-1:0] history [DELAY_DEPTH];
    int newest;
    mixer_out_t awaited_outputs [$];
    int error_count;

    function new();
      foreach (history[i]) history[i] = '0;
      foreach (taps[i]) taps[i] = '0;
      newest = 0;
      error_count = 0;
    endfunction

    function int pending();
      return awaited_outputs.size();
    endfunction

    function void flag(string msg);
      error_count++;
      if (error_count <= 10) $display("%s", msg);
    endfunction

    // Mixer product, then the FIR over the fresh value and the history.
    function mixer_out_t mix_and_filter(logic signed [SAMPLE_W-1:0] msg_s,
                                        logic signed [SAMPLE_W-1:0] car_s);
      logic signed [ACC_W-1:0] prod;
      logic [ACC_W-1:0] acc;
      int term;
      mixer_out_t r;
      prod = int'(msg_s) * int'(car_s);
      r.dsb = prod[FRAC_BITS +: SAMPLE_W];
      term = int'(r.dsb) * int'(taps[0]);
      acc = term;
      for (int k = 0; k < DELAY_DEPTH; k++) begin
        term = int'(history[(newest - k + DELAY_DEPTH) % DELAY_DEPTH]) * int'(taps[k + 1]);
        acc += term;
      end
      r.filtered = acc[FRAC_BITS +: SAMPLE_W];
      // advance the history: the fresh value becomes the newest past value
      newest = (newest + 1) % DELAY_DEPTH;
      history[newest] = r.dsb;
      return r;
    endfunction

    function void note_transfer(logic act,
                                logic signed [SAMPLE_W-1:0] msg_s,
                                logic signed [SAMPLE_W-1:0] car_s,
                                logic [INDEX_W-1:0] idx,
                                logic signed [SAMPLE_W-1:0] coef);
      if (act == ACT_TAP) begin
        // drop writes past the last tap
        if (idx < TAP_COUNT) taps[idx] = coef;
      end else begin
        awaited_outputs.push_back(mix_and_filter(msg_s, car_s));
      end
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] dsb,
                               logic signed [SAMPLE_W-1:0] filtered);
      mixer_out_t want;
      if (awaited_outputs.size() == 0) begin
        flag($sformatf("unexpected result: dsb %0d filtered %0d", dsb, filtered));
        return;
      end
      want = awaited_outputs.pop_front();
      if (dsb !== want.dsb)
        flag($sformatf("dsb_value mismatch: expected %0d got %0d", want.dsb, dsb));
      if (filtered !== want.filtered)
        flag($sformatf("filtered_value mismatch: expected %0d got %0d",
                       want.filtered, filtered));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_action;
  logic signed [SAMPLE_W-1:0] in_modulating_sample;
  logic signed [SAMPLE_W-1:0] in_carrier_sample;
  logic [INDEX_W-1:0] in_tap_index;
  logic signed [SAMPLE_W-1:0] in_tap_value;
  logic out_valid;
  logic out_ready;
  logic signed [SAMPLE_W-1:0] out_dsb_value;
  logic signed [SAMPLE_W-1:0] out_filtered_value;

  dsb_fir_scoreboard sb = new();
  bit tx_burst;
  bit rx_burst;
  int rx_hold;
  longint cycle_count;

  dsb_mixer_fir_filter_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_modulating_sample(in_modulating_sample),
    .in_carrier_sample   (in_carrier_sample),
    .in_tap_index        (in_tap_index),
    .in_tap_value        (in_tap_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_dsb_value       (out_dsb_value),
    .out_filtered_value  (out_filtered_value)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return '0;
      3: return 16'sh0001;
      4: return 16'shFFFF;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Offer one item and hold it until the transfer.
  task automatic send_item(input logic act,
                           input logic signed [SAMPLE_W-1:0] msg_s,
                           input logic signed [SAMPLE_W-1:0] car_s,
                           input logic [INDEX_W-1:0] idx,
                           input logic signed [SAMPLE_W-1:0] coef);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid             <= 1'b1;
    in_action            <= act;
    in_modulating_sample <= msg_s;
    in_carrier_sample    <= car_s;
    in_tap_index         <= idx;
    in_tap_value         <= coef;
    do @(posedge clk); while (!in_ready);
    sb.note_transfer(act, msg_s, car_s, idx, coef);
  endtask

  task automatic send_pair(input logic signed [SAMPLE_W-1:0] msg_s,
                           input logic signed [SAMPLE_W-1:0] car_s);
    send_item(ACT_SAMPLE, msg_s, car_s, INDEX_W'($urandom), SAMPLE_W'($urandom));
  endtask

  task automatic write_tap(input logic [INDEX_W-1:0] idx,
                           input logic signed [SAMPLE_W-1:0] coef);
    send_item(ACT_TAP, SAMPLE_W'($urandom), SAMPLE_W'($urandom), idx, coef);
  endtask

  task automatic load_all_taps(input bit all_min);
    for (int i = 0; i < TAP_COUNT; i++)
      write_tap(INDEX_W'(i), all_min ? 16'sh8000 : pick_sample());
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Result side
  initial begin
    int gap;
    int taken;
    out_ready = 1'b0;
    taken = 0;
    rx_burst = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        gap = rx_hold;
        rx_hold = 0;
      end else begin
        gap = rx_burst ? 0 : $urandom_range(0, 6);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_dsb_value, out_filtered_value);
      taken++;
      if (taken % 16 == 0) rx_burst = ($urandom_range(0, 3) == 0);
    end
  end

  // Item side
  initial begin
    logic [INDEX_W-1:0] idx;
    cycle_count          = 0;
    rx_hold              = 0;
    tx_burst             = 1'b0;
    rst_n                = 1'b0;
    in_valid             = 1'b0;
    in_action            = ACT_SAMPLE;
    in_modulating_sample = '0;
    in_carrier_sample    = '0;
    in_tap_index         = '0;
    in_tap_value         = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Most negative taps everywhere: the sum overflows quickly
    load_all_taps(1'b1);
    send_pair(16'sh8000, 16'sh8000);
    send_pair(16'sh7FFF, 16'sh7FFF);
    send_pair(16'sh8000, 16'sh7FFF);
    send_pair(16'sh7FFF, 16'sh8000);
    send_pair(16'sh0000, 16'sh0000);
    send_pair(16'shFFFF, 16'shFFFF);
    send_pair(16'sh0001, 16'shFFFF);
    send_pair(16'sh4000, 16'sh0002);
    // writes past the last tap leave the filter alone; the rest set taps 1024, 0, 512
    write_tap(11'd1025, 16'sh1234);
    write_tap(11'd2047, 16'shFFFF);
    write_tap(11'd1536, 16'sh7FFF);
    write_tap(11'd1024, 16'sh7FFF);
    write_tap(11'd0, 16'sh7FFF);
    write_tap(11'd512, 16'sh0000);
    send_pair(16'sh8000, 16'sh8000);
    send_pair(16'sh3039, 16'shA460);
    send_pair(16'sh7FFF, 16'sh7FFF);
    send_pair(16'shFFFF, 16'sh7FFF);
    wait_drained();

    load_all_taps(1'b0);
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 40 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      if (n == 200) rx_hold = LONG_HOLD;
      if (n == 400) wait_drained();
      // keep offering pairs back to back while the result side holds off
      if (n >= 200 && n < 208) begin
        tx_burst = 1'b1;
        send_pair(pick_sample(), pick_sample());
      end else if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 6) == 0) idx = INDEX_W'($urandom_range(TAP_COUNT, 2047));
        else idx = INDEX_W'($urandom_range(0, TAP_COUNT - 1));
        write_tap(idx, pick_sample());
      end else begin
        send_pair(pick_sample(), pick_sample());
      end
    end

    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
